>>> rtl/core/assert_macros.svh
// Assertion macros shared by the bound table RTL.
// Included by every module that carries concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is asserted.
`define SKBT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bound table assertion failed");

// Checked on every rising clock edge, reset included.
`define SKBT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("bound table assertion failed");

`endif

>>> rtl/core/skbt_pkg.sv
// Package for the sorted key bound table: field widths, defaults and codes.
// No dependencies; used by the interfaces, the top level and the testbench modules.
package skbt_pkg;

  localparam int KEY_W   = 10;
  localparam int VALUE_W = 17;
  localparam int CFG_W   = 11;

  localparam int NUM_BUCKETS_DEF = 1024;
  localparam int MAX_ITEMS_DEF   = 65536;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1024;

  // item operations
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  // which bound a read returns
  typedef enum logic [1:0] {
    BK_LOWER = 2'd0,
    BK_UPPER = 2'd1,
    BK_COUNT = 2'd2
  } bound_kind_e;

endpackage

>>> rtl/core/skbt_if.sv
// Handshake channels of the bound table: input item and read result item.
// Depends on skbt_pkg for the field widths.
interface skbt_in_if import skbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [KEY_W-1:0]   key;
  logic               last;
  logic [1:0]         bound_kind;

  modport source (output valid, opcode, key, last, bound_kind, input ready);
  modport sink   (input valid, opcode, key, last, bound_kind, output ready);
endinterface

interface skbt_out_if import skbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] bound_value;
  logic               order_error;

  modport source (output valid, bound_value, order_error, input ready);
  modport sink   (input valid, bound_value, order_error, output ready);
endinterface

>>> rtl/core/skbt_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies; read returns the old contents on a same-address write.
module skbt_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sorted_key_bound_table_top.sv
// Top level of the sorted key bound table.
// Depends on skbt_pkg, skbt_if.sv (channels), skbt_ram and assert_macros.svh.
//
// The block takes one item per clock cycle while it is neither clearing nor stalled
// by the result path: key items update the lower and upper bound tables, each held
// in its own single-write-port RAM, and read items return their result through the
// registered RAM read and then the output register. The result path holds one read
// in flight plus one in the output register; when the output side stalls with both
// full, input stalls too. After reset and after every clear item the tables are
// zeroed by a clearing pass over all NUM_BUCKETS entries, one entry of each table per
// cycle, during which no item is accepted; bucket_count writes are taken at any time.
// The upper bound written by a last key is held in a pending register and drained
// into the upper table in the following cycle; reads see it through a bypass.
module sorted_key_bound_table_top
  import skbt_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  skbt_in_if.sink          in_i,
  skbt_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

`include "assert_macros.svh"

  localparam int AW = $clog2(NUM_BUCKETS);
  localparam int PW = $clog2(MAX_ITEMS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BUCKETS - 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_ITEMS);

  // configuration
  logic [CFG_W-1:0] bucket_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // stream state
  logic [KEY_W-1:0] prev_key_q, prev_key_d;
  logic             have_prev_q, have_prev_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic             err_q, err_d;

  // clearing pass
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // pending upper bound from a last key
  logic               pend_valid_q, pend_valid_d;
  logic [AW-1:0]      pend_addr_q, pend_addr_d;
  logic [VALUE_W-1:0] pend_data_q, pend_data_d;

  // read pipeline
  logic               s1_valid_q, s1_valid_d;
  logic [1:0]         s1_kind_q;
  logic               s1_oob_q;
  logic               s1_err_q;
  logic               s1_byp_q;
  logic [VALUE_W-1:0] s1_byp_data_q;
  logic               s1_move;

  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_err_q;

  // RAM ports
  logic               lo_we, up_we;
  logic [AW-1:0]      lo_waddr, up_waddr;
  logic [VALUE_W-1:0] lo_wdata, up_wdata;
  logic [VALUE_W-1:0] lo_rdata, up_rdata;
  logic [AW-1:0]      rd_addr;

  // item decode
  logic in_ready, accept, acc_clear, acc_key, acc_read;
  logic key_in_tbl, key_bad, new_run, close_we;
  logic [PW-1:0] pos_inc;

  assign s1_move  = !out_valid_q || out_o.ready;
  assign in_ready = !clr_busy_q && (!s1_valid_q || s1_move);
  assign accept   = in_i.valid && in_ready;

  assign acc_clear = accept && (opcode_e'(in_i.opcode) == OP_CLEAR);
  assign acc_key   = accept && (opcode_e'(in_i.opcode) == OP_KEY);
  assign acc_read  = accept && (opcode_e'(in_i.opcode) == OP_READ);

  // key checks: range, order and stream length
  assign key_in_tbl = 32'(in_i.key) < NUM_BUCKETS;
  assign key_bad    = ({1'b0, in_i.key} >= bucket_count_q) || !key_in_tbl ||
                      (have_prev_q && (in_i.key < prev_key_q)) ||
                      (pos_q >= POS_LIMIT);
  assign new_run    = !have_prev_q || (in_i.key != prev_key_q);
  assign pos_inc    = pos_q + PW'(1);

  // close the open run at the current position
  assign close_we = acc_key && have_prev_q && (key_bad ? in_i.last : new_run);

  // lower table write port
  always_comb begin
    lo_we    = 1'b0;
    lo_waddr = clr_cnt_q;
    lo_wdata = '0;
    if (clr_busy_q) begin
      lo_we = 1'b1;
    end else if (acc_key && !key_bad && new_run) begin
      lo_we    = 1'b1;
      lo_waddr = AW'(in_i.key);
      lo_wdata = VALUE_W'(pos_q);
    end
  end

  // upper table write port: clearing, then run close, then pending drain
  always_comb begin
    up_we    = 1'b0;
    up_waddr = clr_cnt_q;
    up_wdata = '0;
    priority if (clr_busy_q) begin
      up_we = 1'b1;
    end else if (close_we) begin
      up_we    = 1'b1;
      up_waddr = AW'(prev_key_q);
      up_wdata = VALUE_W'(pos_q);
    end else if (pend_valid_q) begin
      up_we    = 1'b1;
      up_waddr = pend_addr_q;
      up_wdata = pend_data_q;
    end
  end

  assign rd_addr = AW'(in_i.key);

  // next state of stream, clearing pass and pending write
  always_comb begin
    prev_key_d   = prev_key_q;
    have_prev_d  = have_prev_q;
    pos_d        = pos_q;
    err_d        = err_q;
    clr_busy_d   = clr_busy_q;
    clr_cnt_d    = clr_cnt_q;
    pend_valid_d = pend_valid_q && (clr_busy_q || close_we);
    pend_addr_d  = pend_addr_q;
    pend_data_d  = pend_data_q;

    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == LAST_ADDR) begin
        clr_busy_d = 1'b0;
      end
    end

    if (acc_clear) begin
      prev_key_d   = '0;
      have_prev_d  = 1'b0;
      pos_d        = '0;
      err_d        = 1'b0;
      clr_busy_d   = 1'b1;
      clr_cnt_d    = '0;
      pend_valid_d = 1'b0;
    end else if (acc_key) begin
      if (key_bad) begin
        err_d = 1'b1;
        if (in_i.last) begin
          prev_key_d  = '0;
          have_prev_d = 1'b0;
          pos_d       = '0;
        end
      end else if (in_i.last) begin
        prev_key_d   = '0;
        have_prev_d  = 1'b0;
        pos_d        = '0;
        pend_valid_d = 1'b1;
        pend_addr_d  = AW'(in_i.key);
        pend_data_d  = VALUE_W'(pos_inc);
      end else begin
        prev_key_d  = in_i.key;
        have_prev_d = 1'b1;
        pos_d       = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q   <= '0;
      have_prev_q  <= 1'b0;
      pos_q        <= '0;
      err_q        <= 1'b0;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      prev_key_q   <= prev_key_d;
      have_prev_q  <= have_prev_d;
      pos_q        <= pos_d;
      err_q        <= err_d;
      clr_busy_q   <= clr_busy_d;
      clr_cnt_q    <= clr_cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

  // bound tables
  skbt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NUM_BUCKETS)
  ) u_lower_ram (
    .clk_i  (clk_i),
    .we_i   (lo_we),
    .waddr_i(lo_waddr),
    .wdata_i(lo_wdata),
    .re_i   (acc_read),
    .raddr_i(rd_addr),
    .rdata_o(lo_rdata)
  );

  skbt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NUM_BUCKETS)
  ) u_upper_ram (
    .clk_i  (clk_i),
    .we_i   (up_we),
    .waddr_i(up_waddr),
    .wdata_i(up_wdata),
    .re_i   (acc_read),
    .raddr_i(rd_addr),
    .rdata_o(up_rdata)
  );

  // read stage: metadata alongside the RAM read
  always_comb begin
    s1_valid_d = s1_valid_q && !s1_move;
    if (acc_read) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_read) begin
      s1_kind_q     <= in_i.bound_kind;
      s1_oob_q      <= !key_in_tbl;
      s1_err_q      <= err_q;
      s1_byp_q      <= pend_valid_q && (pend_addr_q == rd_addr);
      s1_byp_data_q <= pend_data_q;
    end
  end

  // result selection
  logic [VALUE_W-1:0] up_val;

  assign up_val = s1_byp_q ? s1_byp_data_q : up_rdata;

  always_comb begin
    unique case (bound_kind_e'(s1_kind_q))
      BK_LOWER: out_value_d = lo_rdata;
      BK_UPPER: out_value_d = up_val;
      BK_COUNT: out_value_d = (up_val >= lo_rdata) ? (up_val - lo_rdata) : '0;
      default:  out_value_d = '0;
    endcase
    if (s1_oob_q) begin
      out_value_d = '0;
    end
  end

  // output register
  assign out_valid_d = s1_move ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_value_q <= out_value_d;
      out_err_q   <= s1_err_q;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.bound_value = out_value_q;
  assign out_o.order_error = out_err_q;

  // no item is taken while the tables are being cleared
  `SKBT_ASSERT(a_no_accept_clearing, clk_i, rst_ni, clr_busy_q |-> !in_ready)
  // a clear item always starts a clearing pass
  `SKBT_ASSERT(a_clear_starts_pass, clk_i, rst_ni, acc_clear |=> clr_busy_q)
  // a pending upper bound is always drained before the next run close
  `SKBT_ASSERT(a_pend_no_conflict, clk_i, rst_ni, close_we |-> !pend_valid_q)
  // a stalled read keeps its RAM data
  `SKBT_ASSERT(a_stall_holds_rdata, clk_i, rst_ni,
               (s1_valid_q && !s1_move) |=> ($stable(lo_rdata) && $stable(up_rdata)))

endmodule

>>> tb/sv/skbt_bound_checker.sv
// Checker for the sorted key bound table: watches both channels and the config port,
// keeps its own copy of the bound tables and compares every read result item.
// Depends on skbt_pkg and the channel interfaces in skbt_if.sv.
module skbt_bound_checker
  import skbt_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int MAX_PRINT   = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  skbt_in_if               in_mon_i,
  skbt_out_if              out_mon_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             done_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               read_count_o,
  output int               reject_count_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] bound_value;
    logic               order_error;
  } bound_answer_t;

  // predicted table contents and stream state
  logic [VALUE_W-1:0] lower_tbl [NUM_BUCKETS];
  logic [VALUE_W-1:0] upper_tbl [NUM_BUCKETS];
  logic [KEY_W-1:0]   run_key;
  logic               run_open;
  logic [VALUE_W-1:0] position;
  logic               sticky_err;
  logic [CFG_W-1:0]   bucket_count;

  bound_answer_t answer_q [$];
  bound_answer_t oldest;
  logic          leftovers_checked;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_tables();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      lower_tbl[i] = '0;
      upper_tbl[i] = '0;
    end
    run_key    = '0;
    run_open   = 1'b0;
    position   = '0;
    sticky_err = 1'b0;
  endtask

  // the open run ends at pos
  task automatic close_run(input logic [VALUE_W-1:0] pos);
    if (run_open && int'(run_key) < NUM_BUCKETS) upper_tbl[run_key] = pos;
  endtask

  task automatic end_stream();
    run_open = 1'b0;
    run_key  = '0;
    position = '0;
  endtask

  // one key item of the sorted stream
  task automatic take_key(input logic [KEY_W-1:0] k, input logic lst);
    int   limit;
    logic bad;
    limit = (int'(bucket_count) < NUM_BUCKETS) ? int'(bucket_count) : NUM_BUCKETS;
    bad = (int'(k) >= limit) || (run_open && k < run_key) || (int'(position) >= MAX_ITEMS);
    if (bad) begin
      sticky_err = 1'b1;
      reject_count_o++;
      // a rejected last key still closes the open run
      if (lst) begin
        close_run(position);
        end_stream();
      end
    end else begin
      if (!run_open || k != run_key) begin
        lower_tbl[k] = position;
        close_run(position);
      end
      position = position + 1'b1;
      run_key  = k;
      run_open = 1'b1;
      if (lst) begin
        upper_tbl[k] = position;
        end_stream();
      end
    end
  endtask

  // selected bound of one bucket; a stale upper below the lower gives count zero
  function automatic logic [VALUE_W-1:0] bound_of(input logic [KEY_W-1:0] k,
                                                  input logic [1:0] kind);
    logic [VALUE_W-1:0] lo, up;
    if (int'(k) >= NUM_BUCKETS) return '0;
    lo = lower_tbl[k];
    up = upper_tbl[k];
    case (kind)
      BK_LOWER: return lo;
      BK_UPPER: return up;
      BK_COUNT: return (up >= lo) ? up - lo : '0;
      default:  return '0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tables();
      bucket_count = BUCKET_COUNT_RST;
      answer_q.delete();
      fail_count_o      = 0;
      read_count_o      = 0;
      reject_count_o    = 0;
      leftovers_checked = 1'b0;
    end else begin
      // result side: compare with the oldest waiting read
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with no read waiting: value %0d error %0b",
                                    out_mon_i.bound_value, out_mon_i.order_error));
        end else begin
          oldest = answer_q.pop_front();
          if (out_mon_i.bound_value !== oldest.bound_value)
            report_mismatch($sformatf("bound_value %0d, expected %0d",
                                      out_mon_i.bound_value, oldest.bound_value));
          if (out_mon_i.order_error !== oldest.order_error)
            report_mismatch($sformatf("order_error %0b, expected %0b",
                                      out_mon_i.order_error, oldest.order_error));
        end
      end
      // config writes only happen while no item is moving
      if (cfg_we_i) bucket_count = cfg_wdata_i;
      // input side: update the tables
      if (in_mon_i.valid && in_mon_i.ready) begin
        case (in_mon_i.opcode)
          OP_CLEAR: clear_tables();
          OP_KEY:   take_key(in_mon_i.key, in_mon_i.last);
          OP_READ: begin
            answer_q.push_back('{bound_value: bound_of(in_mon_i.key, in_mon_i.bound_kind),
                                 order_error: sticky_err});
            read_count_o++;
          end
          default: ;
        endcase
      end
      // end of run: anything still waiting never came out
      if (done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        while (answer_q.size() != 0) begin
          oldest = answer_q.pop_front();
          report_mismatch($sformatf("missing result: value %0d error %0b",
                                    oldest.bound_value, oldest.order_error));
        end
      end
    end
    pending_o = answer_q.size();
  end

endmodule

>>> tb/sv/tb_sorted_key_bound_table_top.sv
// Testbench top for the sorted key bound table: clock, reset, item and config stimulus.
// Depends on skbt_pkg, skbt_if.sv, the block's RTL and skbt_bound_checker.
module tb_sorted_key_bound_table_top;
  import skbt_pkg::*;

  localparam int IDLE_PCT       = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5 * (NUM_BUCKETS_DEF + 200);
  localparam int PHASE_ITEMS    = 75;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             done;

  int fail_count;
  int pending;
  int read_count;
  int reject_count;

  int idle_pct   = IDLE_PCT;
  int sent_count = 0;
  int recent_key = 0;
  int settings   = 0;

  skbt_in_if  in_ch ();
  skbt_out_if out_ch ();

  sorted_key_bound_table_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  skbt_bound_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_ch),
    .out_mon_i      (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .done_i         (done),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .read_count_o   (read_count),
    .reject_count_o (reject_count)
  );

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, changed at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // cycles without any accepted item end the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // drive one item, wait for its acceptance; starts and ends at a falling edge
  task automatic send_item(input opcode_e op, input logic [KEY_W-1:0] k, input logic lst,
                           input logic [1:0] kind);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.opcode     = op;
    in_ch.key        = k;
    in_ch.last       = lst;
    in_ch.bound_kind = kind;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op != OP_NOP) sent_count++;
  endtask

  task automatic send_key(input int k, input logic lst);
    send_item(OP_KEY, k[KEY_W-1:0], lst, 2'($urandom_range(3)));
  endtask

  task automatic send_read(input int k, input bound_kind_e kind);
    send_item(OP_READ, k[KEY_W-1:0], 1'($urandom_range(1)), kind);
  endtask

  // hold off until every read has answered and the block has gone quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_bucket_count(input int value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we    = 1'b0;
    settings++;
  endtask

  // read biased toward the keys just streamed
  task automatic send_random_read(input int limit);
    int k;
    case ($urandom_range(2))
      0:       k = $urandom_range(1023);
      1:       k = (limit > 1) ? $urandom_range(limit - 1) : 0;
      default: k = recent_key - $urandom_range(2);
    endcase
    if (k < 0) k = 0;
    send_item(OP_READ, k[KEY_W-1:0], 1'($urandom_range(1)), 2'($urandom_range(3)));
  endtask

  // ascending keys with repeats, mostly closed by a last key, a few out of order
  task automatic send_random_stream(input int limit);
    int   len, step, k;
    logic lst;
    len  = $urandom_range(12, 1);
    step = limit / (len + 1) + 1;
    k    = (limit > 1) ? $urandom_range(limit / 2) : 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 20) send_random_read(limit);
      if ($urandom_range(99) < 5) k = $urandom_range(1023);
      lst = (i == len - 1) && ($urandom_range(99) < 85);
      recent_key = k;
      send_key(k, lst);
      if ($urandom_range(1) != 0) k = k + $urandom_range(step);
      if (k > 1023) k = 1023;
      if (limit > 0 && k >= limit) k = limit - 1;
    end
    if ($urandom_range(1) != 0) send_random_read(limit);
  endtask

  task automatic random_items(input int n_items, input int limit);
    int start, r;
    start = sent_count;
    while (sent_count - start < n_items) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(OP_CLEAR, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                  2'($urandom_range(3)));
      end else if (r < 13) begin
        send_item(opcode_e'($urandom_range(3)), 10'($urandom_range(1023)),
                  1'($urandom_range(1)), 2'($urandom_range(3)));
      end else if (r < 28) begin
        send_random_read(limit);
      end else begin
        send_random_stream(limit);
      end
    end
  endtask

  task automatic random_phase(input int value, input int n_items);
    write_bucket_count(value);
    random_items(n_items, (value < NUM_BUCKETS_DEF) ? value : NUM_BUCKETS_DEF);
  endtask

  initial begin
    int mid, tiny;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    done             = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_NOP;
    in_ch.key        = '0;
    in_ch.last       = 1'b0;
    in_ch.bound_kind = BK_LOWER;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset contents, runs, stale count, rejects, nop and clear
    send_read(0, BK_LOWER);
    send_read(1023, BK_COUNT);
    send_key(0, 1'b0);
    send_key(0, 1'b0);
    send_key(5, 1'b0);
    send_key(5, 1'b0);
    send_key(5, 1'b0);
    send_key(1023, 1'b1);
    send_read(5, BK_LOWER);
    send_read(5, BK_UPPER);
    send_read(5, BK_COUNT);
    send_item(OP_READ, 10'd1023, 1'b0, 2'd3);
    send_read(1023, BK_UPPER);
    // new run on key 5 lands above its old upper bound
    repeat (6) send_key(0, 1'b0);
    send_key(5, 1'b0);
    send_read(5, BK_COUNT);
    // key below the open run is rejected
    send_key(3, 1'b0);
    send_read(0, BK_LOWER);
    // rejected last key still closes the run
    send_key(2, 1'b1);
    send_read(5, BK_UPPER);
    send_item(OP_NOP, 10'h3FF, 1'b1, 2'd3);
    send_item(OP_CLEAR, 10'h155, 1'b0, 2'd1);
    send_read(5, BK_UPPER);

    random_items(PHASE_ITEMS, NUM_BUCKETS_DEF);
    random_phase(1, PHASE_ITEMS);
    random_phase(2047, PHASE_ITEMS);
    random_phase(0, PHASE_ITEMS / 2);

    // a stretch with no idling on either side
    idle_pct = 0;
    random_phase(1024, PHASE_ITEMS);
    idle_pct = IDLE_PCT;

    mid  = $urandom_range(1023, 2);
    tiny = $urandom_range(16, 2);
    random_phase(mid, PHASE_ITEMS);
    random_phase(tiny, PHASE_ITEMS);
    random_phase(1024, PHASE_ITEMS);

    // wait out the last results, then close the books
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    done = 1'b1;
    @(negedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d items: %0d reads answered, %0d keys rejected, %0d bucket_count writes,",
             sent_count, read_count, reject_count, settings);
    $display("with bucket limits 0, 1, %0d, %0d and past the table, one phase without idling.",
             tiny, mid);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/skbt_pkg.sv
rtl/core/skbt_if.sv
rtl/core/skbt_ram.sv
rtl/core/sorted_key_bound_table_top.sv
tb/sv/skbt_bound_checker.sv
tb/sv/tb_sorted_key_bound_table_top.sv
